@@ hdl/lts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and constants of the tagged slot table: field widths,
// operation codes, the entry record and the per-cell control group.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 16;
  localparam int LEN_W   = 32;
  localparam int SLOT_W  = 5;
  localparam int STAMP_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   id;
    logic [LEN_W-1:0]   len;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic stamp_we;
  } cell_ctl_t;

endpackage

@@ hdl/lts_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_if
// Request and result channels of the tagged slot table, valid/ready.
// ----------------------------------------------------------------------------
interface lts_in_if;
  logic                       valid;
  logic                       ready;
  logic [lts_pkg::FUNC_W-1:0] func;
  logic [lts_pkg::KEY_W-1:0]  key_id;
  logic [lts_pkg::LEN_W-1:0]  byte_length;
  logic [lts_pkg::SLOT_W-1:0] slot_sel;

  modport source (output valid, func, key_id, byte_length, slot_sel, input ready);
  modport sink   (input valid, func, key_id, byte_length, slot_sel, output ready);
endinterface

interface lts_out_if;
  logic                       valid;
  logic                       ready;
  logic [lts_pkg::SLOT_W-1:0] slot_index;
  logic                       hit;
  logic [lts_pkg::LEN_W-1:0]  entry_length;
  logic                       evicted;
  logic [lts_pkg::KEY_W-1:0]  evicted_id;
  logic                       status;

  modport source (output valid, slot_index, hit, entry_length, evicted, evicted_id,
                  status, input ready);
  modport sink   (input valid, slot_index, hit, entry_length, evicted, evicted_id,
                  status, output ready);
endinterface

@@ hdl/lts_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_cell
// One table slot. Takes its right neighbor's entry on a compaction shift,
// loads a new entry on append, or refreshes its stamp on a lookup hit.
// ----------------------------------------------------------------------------
module lts_cell (
  input  logic               clk,
  input  lts_pkg::cell_ctl_t ctl,
  input  lts_pkg::entry_t    nbr_ent,
  input  lts_pkg::entry_t    wr_ent,
  output lts_pkg::entry_t    ent
);

  lts_pkg::entry_t ent_r;
  lts_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.shift) begin
      ent_nxt = nbr_ent;
    end else if (ctl.load) begin
      ent_nxt = wr_ent;
    end else if (ctl.stamp_we) begin
      ent_nxt.stamp = wr_ent.stamp;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

@@ hdl/lru_tagged_slot_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_tagged_slot_table
// Compacted LRU directory of tagged slots built as a row of entry cells.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A controller scans the row of cells one
// slot per cycle through a slot select; an insert runs an id search, an LRU
// search when the table is full, and an append. Removing a slot compacts
// the table in one register update: every cell at or above the removed slot
// takes its right neighbor's entry. The result waits in an output register,
// and a new item is taken while it waits. No clearing pass after reset is
// needed.
// ----------------------------------------------------------------------------
module lru_tagged_slot_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst_n,
  lts_in_if.sink    in_chan,
  lts_out_if.source out_chan
);

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > lts_pkg::SLOT_W) ? CW : lts_pkg::SLOT_W;
  localparam int XW   = CMPW + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_CHK, ST_LRU, ST_APPEND, ST_FREE, ST_DONE
  } state_t;

  state_t state_r;

  logic [lts_pkg::FUNC_W-1:0]  func_r;
  logic [lts_pkg::KEY_W-1:0]   key_r;
  logic [lts_pkg::LEN_W-1:0]   len_r;
  logic [lts_pkg::SLOT_W-1:0]  sel_r;

  logic [CW-1:0]               count_r;
  logic [CW-1:0]               idx_r;
  logic [CW-1:0]               best_r;
  logic [lts_pkg::KEY_W-1:0]   best_id_r;
  logic [lts_pkg::STAMP_W-1:0] least_r;
  logic [lts_pkg::STAMP_W-1:0] cnt_r;

  logic [lts_pkg::SLOT_W-1:0]  res_slot_r;
  logic                        res_hit_r;
  logic [lts_pkg::LEN_W-1:0]   res_elen_r;
  logic                        res_ev_r;
  logic [lts_pkg::KEY_W-1:0]   res_evid_r;
  logic                        res_status_r;

  logic                        out_valid_r;
  logic [lts_pkg::SLOT_W-1:0]  out_slot_r;
  logic                        out_hit_r;
  logic [lts_pkg::LEN_W-1:0]   out_elen_r;
  logic                        out_ev_r;
  logic [lts_pkg::KEY_W-1:0]   out_evid_r;
  logic                        out_status_r;

  lts_pkg::entry_t   cell_q [MAX_ENTRIES];
  lts_pkg::cell_ctl_t cell_ctl [MAX_ENTRIES];
  lts_pkg::entry_t   wr_ent;
  lts_pkg::entry_t   cur;

  logic [lts_pkg::STAMP_W-1:0] cnt_inc;
  logic [CMPW-1:0]             sel_ext;
  logic [CMPW-1:0]             count_ext;
  logic                        sel_beyond;
  logic [XW-1:0]               idx_x;
  logic [XW-1:0]               count_x;
  logic                        cur_end;
  logic                        id_match;
  logic                        rm_go;
  logic [CW-1:0]               rm_pos;
  logic                        ld_go;
  logic                        st_go;

  assign cnt_inc    = cnt_r + lts_pkg::STAMP_W'(1);
  assign sel_ext    = CMPW'(sel_r);
  assign count_ext  = CMPW'(count_r);
  assign sel_beyond = sel_ext > count_ext;
  assign idx_x      = XW'(idx_r) + XW'(1);
  assign count_x    = XW'(count_r) + XW'(1);
  assign cur_end    = idx_r == count_r;
  assign id_match   = cur.id == key_r;
  assign wr_ent     = '{id: key_r, len: len_r, stamp: cnt_inc};

  always_comb begin
    cur = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (idx_r == CW'(k)) begin
        cur = cell_q[k];
      end
    end
  end

  always_comb begin
    rm_go  = 1'b0;
    rm_pos = idx_r;
    ld_go  = 1'b0;
    st_go  = 1'b0;
    case (state_r)
      ST_SCAN: begin
        if (!cur_end && id_match) begin
          if (func_r == lts_pkg::FUNC_INSERT) begin
            rm_go = 1'b1;
          end else begin
            st_go = 1'b1;
          end
        end
      end
      ST_LRU: begin
        if (cur_end) begin
          rm_go  = 1'b1;
          rm_pos = best_r;
        end
      end
      ST_FREE: begin
        if (sel_r != '0 && !sel_beyond) begin
          rm_go  = 1'b1;
          rm_pos = CW'(sel_ext - CMPW'(1));
        end
      end
      ST_APPEND: begin
        ld_go = 1'b1;
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    lts_pkg::entry_t nbr;

    if (k == MAX_ENTRIES - 1) begin : g_last
      assign nbr = cell_q[k];
    end else begin : g_mid
      assign nbr = cell_q[k+1];
    end

    assign cell_ctl[k] = '{shift:    rm_go && (CW'(k) >= rm_pos),
                           load:     ld_go && (CW'(k) == count_r),
                           stamp_we: st_go && (CW'(k) == idx_r)};

    lts_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[k]),
      .nbr_ent (nbr),
      .wr_ent  (wr_ent),
      .ent     (cell_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            func_r       <= in_chan.func;
            key_r        <= in_chan.key_id;
            len_r        <= in_chan.byte_length;
            sel_r        <= in_chan.slot_sel;
            idx_r        <= '0;
            res_slot_r   <= '0;
            res_hit_r    <= 1'b0;
            res_elen_r   <= '0;
            res_ev_r     <= 1'b0;
            res_evid_r   <= '0;
            res_status_r <= 1'b0;
            case (in_chan.func)
              lts_pkg::FUNC_LOOKUP: state_r <= ST_SCAN;
              lts_pkg::FUNC_INSERT: state_r <= ST_SCAN;
              lts_pkg::FUNC_FREE:   state_r <= ST_FREE;
              default:              state_r <= ST_DONE;
            endcase
          end
        end
        ST_SCAN: begin
          if (cur_end) begin
            state_r <= (func_r == lts_pkg::FUNC_INSERT) ? ST_CHK : ST_DONE;
          end else if (id_match) begin
            cnt_r     <= cnt_inc;
            res_hit_r <= 1'b1;
            if (func_r == lts_pkg::FUNC_INSERT) begin
              count_r <= count_r - CW'(1);
              state_r <= ST_CHK;
            end else begin
              res_slot_r <= idx_x[lts_pkg::SLOT_W-1:0];
              res_elen_r <= cur.len;
              state_r    <= ST_DONE;
            end
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        ST_CHK: begin
          if (count_r >= CW'(MAX_ENTRIES)) begin
            idx_r   <= '0;
            least_r <= '1;
            best_r  <= '0;
            state_r <= ST_LRU;
          end else begin
            state_r <= ST_APPEND;
          end
        end
        ST_LRU: begin
          if (cur_end) begin
            res_ev_r   <= 1'b1;
            res_evid_r <= best_id_r;
            count_r    <= count_r - CW'(1);
            state_r    <= ST_APPEND;
          end else begin
            if (cur.stamp <= least_r) begin
              least_r   <= cur.stamp;
              best_r    <= idx_r;
              best_id_r <= cur.id;
            end
            idx_r <= idx_r + CW'(1);
          end
        end
        ST_APPEND: begin
          cnt_r      <= cnt_inc;
          count_r    <= count_r + CW'(1);
          res_slot_r <= count_x[lts_pkg::SLOT_W-1:0];
          res_elen_r <= len_r;
          state_r    <= ST_DONE;
        end
        ST_FREE: begin
          if (sel_r == '0) begin
            count_r <= '0;
          end else if (sel_beyond) begin
            res_status_r <= 1'b1;
          end else begin
            count_r <= count_r - CW'(1);
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_slot_r   <= res_slot_r;
            out_hit_r    <= res_hit_r;
            out_elen_r   <= res_elen_r;
            out_ev_r     <= res_ev_r;
            out_evid_r   <= res_evid_r;
            out_status_r <= res_status_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready         = state_r == ST_IDLE;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.slot_index   = out_slot_r;
  assign out_chan.hit          = out_hit_r;
  assign out_chan.entry_length = out_elen_r;
  assign out_chan.evicted      = out_ev_r;
  assign out_chan.evicted_id   = out_evid_r;
  assign out_chan.status       = out_status_r;

endmodule

@@ dv/lru_tagged_slot_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_tagged_slot_table_tb
// Self-checking bench for the tagged slot table. A short table of directed
// items covers the empty table, bad frees, the unused operation, extreme ids
// and lengths, a filled table and an eviction. Random lookups, inserts and
// frees over shifting id pools follow. Each result is checked against the
// typed reply or an in-bench model; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module lru_tagged_slot_table_tb;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [lts_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef logic [lts_pkg::SLOT_W-1:0] slot_t;
  typedef logic [lts_pkg::KEY_W-1:0]  key_t;
  typedef logic [31:0]                word_t;

  typedef struct packed {
    logic [lts_pkg::FUNC_W-1:0] func;
    logic [lts_pkg::KEY_W-1:0]  key_id;
    logic [lts_pkg::LEN_W-1:0]  byte_length;
    logic [lts_pkg::SLOT_W-1:0] slot_sel;
  } request_t;

  typedef struct packed {
    logic [lts_pkg::SLOT_W-1:0] slot_index;
    logic                       hit;
    logic [lts_pkg::LEN_W-1:0]  entry_length;
    logic                       evicted;
    logic [lts_pkg::KEY_W-1:0]  evicted_id;
    logic                       status;
  } reply_t;

  typedef struct packed {
    logic [lts_pkg::FUNC_W-1:0] func;
    logic [lts_pkg::KEY_W-1:0]  key_id;
    logic [lts_pkg::LEN_W-1:0]  byte_length;
    logic [lts_pkg::SLOT_W-1:0] slot_sel;
    logic [7:0]                 reps;
    logic                       typed;
    reply_t                     want;
  } plan_row_t;

  // Reps > 1 steps the id by one per item.
  plan_row_t plan [0:16] = '{
    '{lts_pkg::FUNC_LOOKUP, 16'h0000, 32'h0000_0000, 5'd0,  8'd1,  1'b1,
      '{5'd0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0}},
    '{lts_pkg::FUNC_FREE,   16'h0000, 32'h0000_0000, 5'd0,  8'd1,  1'b1,
      '{5'd0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0}},
    '{lts_pkg::FUNC_FREE,   16'h0000, 32'h0000_0000, 5'd1,  8'd1,  1'b1,
      '{5'd0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b1}},
    '{lts_pkg::FUNC_FREE,   16'hFFFF, 32'hFFFF_FFFF, 5'd31, 8'd1,  1'b1,
      '{5'd0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b1}},
    '{FUNC_UNUSED,          16'hFFFF, 32'hFFFF_FFFF, 5'd31, 8'd1,  1'b1,
      '{5'd0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0}},
    '{lts_pkg::FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 5'd0,  8'd1,  1'b1,
      '{5'd1, 1'b0, 32'hFFFF_FFFF, 1'b0, 16'h0, 1'b0}},
    '{lts_pkg::FUNC_INSERT, 16'h0000, 32'h0000_0000, 5'd31, 8'd1,  1'b1,
      '{5'd2, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0}},
    '{lts_pkg::FUNC_LOOKUP, 16'hFFFF, 32'h0000_0000, 5'd0,  8'd1,  1'b1,
      '{5'd1, 1'b1, 32'hFFFF_FFFF, 1'b0, 16'h0, 1'b0}},
    '{lts_pkg::FUNC_INSERT, 16'hFFFF, 32'h0000_0005, 5'd0,  8'd1,  1'b0, '0},
    '{lts_pkg::FUNC_INSERT, 16'h0100, 32'h1234_5678, 5'd0,  8'd14, 1'b0, '0},
    '{lts_pkg::FUNC_LOOKUP, 16'h0000, 32'h0000_0000, 5'd0,  8'd1,  1'b0, '0},
    '{lts_pkg::FUNC_INSERT, 16'hABCD, 32'h8000_0001, 5'd0,  8'd1,  1'b0, '0},
    '{lts_pkg::FUNC_FREE,   16'h0000, 32'h0000_0000, 5'd16, 8'd1,  1'b0, '0},
    '{lts_pkg::FUNC_FREE,   16'h0000, 32'h0000_0000, 5'd16, 8'd1,  1'b1,
      '{5'd0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b1}},
    '{lts_pkg::FUNC_FREE,   16'h0000, 32'h0000_0000, 5'd1,  8'd1,  1'b0, '0},
    '{lts_pkg::FUNC_FREE,   16'h0000, 32'h0000_0000, 5'd0,  8'd1,  1'b1,
      '{5'd0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0}},
    '{lts_pkg::FUNC_LOOKUP, 16'hABCD, 32'h0000_0000, 5'd0,  8'd1,  1'b1,
      '{5'd0, 1'b0, 32'h0, 1'b0, 16'h0, 1'b0}}
  };

  logic clk;
  logic rst_n;

  lts_in_if  in_chan ();
  lts_out_if out_chan ();

  lru_tagged_slot_table #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Table model
  logic [lts_pkg::KEY_W-1:0]   tbl_id    [TABLE_DEPTH];
  logic [lts_pkg::LEN_W-1:0]   tbl_len   [TABLE_DEPTH];
  logic [lts_pkg::STAMP_W-1:0] tbl_stamp [TABLE_DEPTH];
  int unsigned                 tbl_count;
  logic [lts_pkg::STAMP_W-1:0] use_clock;

  reply_t      pending_replies [$];
  reply_t      head;
  int unsigned fault_count;
  int unsigned replies_taken;
  int unsigned run_left [2];
  bit          calm [2];
  logic [lts_pkg::KEY_W-1:0] key_pool [$];

  function automatic int unsigned table_find(logic [lts_pkg::KEY_W-1:0] key);
    for (int k = 0; k < tbl_count; k++) begin
      if (tbl_id[k] == key) begin
        use_clock = use_clock + 1;
        tbl_stamp[k] = use_clock;
        return k + 1;
      end
    end
    return 0;
  endfunction

  function automatic void table_drop(int unsigned s);
    for (int k = s - 1; k + 1 < tbl_count; k++) begin
      tbl_id[k]    = tbl_id[k + 1];
      tbl_len[k]   = tbl_len[k + 1];
      tbl_stamp[k] = tbl_stamp[k + 1];
    end
    tbl_count = tbl_count - 1;
  endfunction

  function automatic reply_t table_apply(request_t r);
    reply_t                      o;
    int unsigned                 s;
    logic [lts_pkg::STAMP_W-1:0] least;
    o = '0;
    case (r.func)
      lts_pkg::FUNC_LOOKUP: begin
        s = table_find(r.key_id);
        if (s != 0) begin
          o.slot_index   = slot_t'(s);
          o.hit          = 1'b1;
          o.entry_length = tbl_len[s - 1];
        end
      end
      lts_pkg::FUNC_INSERT: begin
        s = table_find(r.key_id);
        if (s != 0) begin
          o.hit = 1'b1;
          table_drop(s);
        end
        if (tbl_count >= TABLE_DEPTH) begin
          least = '1;
          s = 0;
          for (int k = 0; k < tbl_count; k++) begin
            if (tbl_stamp[k] <= least) begin
              least = tbl_stamp[k];
              s = k + 1;
            end
          end
          o.evicted    = 1'b1;
          o.evicted_id = tbl_id[s - 1];
          table_drop(s);
        end
        use_clock = use_clock + 1;
        tbl_id[tbl_count]    = r.key_id;
        tbl_len[tbl_count]   = r.byte_length;
        tbl_stamp[tbl_count] = use_clock;
        tbl_count = tbl_count + 1;
        o.slot_index   = slot_t'(tbl_count);
        o.entry_length = r.byte_length;
      end
      lts_pkg::FUNC_FREE: begin
        if (r.slot_sel == 0) begin
          tbl_count = 0;
        end else if (r.slot_sel > tbl_count) begin
          o.status = 1'b1;
        end else begin
          table_drop(word_t'(r.slot_sel));
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Side 0 sends, side 1 receives; runs of items are drawn calm or bursty at random.
  function automatic int unsigned idle_draw(int side);
    if (run_left[side] == 0) begin
      run_left[side] = $urandom_range(10, 60);
      calm[side] = ($urandom_range(0, 2) == 0);
    end
    run_left[side] = run_left[side] - 1;
    return calm[side] ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count++;
    end
  endfunction

  task automatic offer(request_t r, bit typed, reply_t want);
    int unsigned gap;
    reply_t      got;
    gap = idle_draw(0);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.func        <= r.func;
    in_chan.key_id      <= r.key_id;
    in_chan.byte_length <= r.byte_length;
    in_chan.slot_sel    <= r.slot_sel;
    do @(posedge clk); while (!in_chan.ready);
    got = table_apply(r);
    pending_replies.push_back(typed ? want : got);
  endtask

  always #5 clk = ~clk;

  initial begin
    #6_000_000;
    $display("lru_tagged_slot_table_tb: done, errors");
    $finish;
  end

  // Result side
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && replies_taken >= 150) begin
        held = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = idle_draw(1);
      end
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      replies_taken++;
      if (pending_replies.size() == 0) begin
        $error("result with no item outstanding");
        fault_count++;
      end else begin
        head = pending_replies.pop_front();
        check_field("slot_index", word_t'(head.slot_index), word_t'(out_chan.slot_index));
        check_field("hit", word_t'(head.hit), word_t'(out_chan.hit));
        check_field("entry_length", head.entry_length, out_chan.entry_length);
        check_field("evicted", word_t'(head.evicted), word_t'(out_chan.evicted));
        check_field("evicted_id", word_t'(head.evicted_id), word_t'(out_chan.evicted_id));
        check_field("status", word_t'(head.status), word_t'(out_chan.status));
      end
    end
  end

  // Request side
  initial begin
    request_t    r;
    int unsigned pick;
    int unsigned pool_size;
    clk = 1'b0;
    rst_n <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.func        <= lts_pkg::FUNC_LOOKUP;
    in_chan.key_id      <= '0;
    in_chan.byte_length <= '0;
    in_chan.slot_sel    <= '0;
    tbl_count = 0;
    use_clock = '0;
    fault_count = 0;
    replies_taken = 0;
    run_left = '{0, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(plan); i++) begin
      for (int j = 0; j < plan[i].reps; j++) begin
        r.func        = plan[i].func;
        r.key_id      = key_t'(plan[i].key_id + j);
        r.byte_length = plan[i].byte_length;
        r.slot_sel    = plan[i].slot_sel;
        offer(r, plan[i].typed, plan[i].want);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // redraw the id pool so the table alternates between fitting and thrashing
      if (n % 200 == 0) begin
        key_pool.delete();
        pool_size = $urandom_range(4, 40);
        repeat (pool_size) key_pool.push_back(key_t'($urandom_range(0, 65535)));
      end
      pick = $urandom_range(0, 99);
      r.byte_length = $urandom();
      r.slot_sel    = slot_t'($urandom_range(0, 31));
      r.key_id      = ($urandom_range(0, 6) == 0) ? key_t'($urandom_range(0, 65535))
                                                  : key_pool[$urandom_range(0, pool_size - 1)];
      if (pick < 45) begin
        r.func = lts_pkg::FUNC_INSERT;
      end else if (pick < 85) begin
        r.func = lts_pkg::FUNC_LOOKUP;
      end else if (pick < 97) begin
        r.func = lts_pkg::FUNC_FREE;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          r.slot_sel = '0;
        end else if (pick < 16) begin
          r.slot_sel = (tbl_count == 0) ? slot_t'(1)
                                        : slot_t'($urandom_range(1, tbl_count));
        end
      end else begin
        r.func = FUNC_UNUSED;
      end
      offer(r, 1'b0, '0);
    end
    in_chan.valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fault_count == 0) begin
      $display("lru_tagged_slot_table_tb: done, clean");
    end else begin
      $display("lru_tagged_slot_table_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ lru_tagged_slot_table.f @@
hdl/lts_pkg.sv
hdl/lts_if.sv
hdl/lts_cell.sv
hdl/lru_tagged_slot_table.sv
dv/lru_tagged_slot_table_tb.sv
